// ----- sv/cph_pkg.sv -----
// shared types, codes and helpers for the conditional pixel histogram
`default_nettype none

package cph_pkg;

    // default sizes
    localparam int DEF_NUM_BINS   = 256;
    localparam int DEF_COUNT_BITS = 32;

    // field widths
    localparam int PIX_W      = 8;
    localparam int FUNC_W     = 2;
    localparam int MODE_W     = 3;
    localparam int FIELD_W    = 32;
    localparam int S_DATA_W   = 3 * PIX_W;
    localparam int M_DATA_W   = PIX_W + FIELD_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes, taken from paddr[2]
    localparam logic REG_COMPARE_MODE  = 1'b0;
    localparam logic REG_COMPARE_VALUE = 1'b1;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ACCUM      = 2'd0,
        FUNC_READ       = 2'd1,
        FUNC_READ_CLEAR = 2'd2
    } func_t;

    // compare modes
    typedef enum logic [MODE_W-1:0] {
        CMP_EQ = 3'd0,
        CMP_NE = 3'd1,
        CMP_GT = 3'd2,
        CMP_GE = 3'd3,
        CMP_LT = 3'd4,
        CMP_LE = 3'd5
    } cmp_mode_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PIX_W-1:0]  value;
    } cfg_t;

    // mask pixel qualification, unused modes never hold
    function automatic logic cond_holds(input cfg_t cfg, input logic [PIX_W-1:0] m);
        logic hit;
        case (cfg.mode)
            CMP_EQ:  hit = (m == cfg.value);
            CMP_NE:  hit = (m != cfg.value);
            CMP_GT:  hit = (m > cfg.value);
            CMP_GE:  hit = (m >= cfg.value);
            CMP_LT:  hit = (m < cfg.value);
            CMP_LE:  hit = (m <= cfg.value);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- sv/conditional_pixel_histogram_unit.sv -----
// Conditional pixel histogram: accepts one word per cycle, back to back, unless a read stalls input.
// A read result passes through the stage one registers and then into the output register.
// Throughput: one word per cycle, set by the registered read of the bin memory and the
// write-back forwarding; a read stalls input only while the previous result waits.
// Reset clears all valid bits at once, so every bin reads zero; no clearing pass.
`default_nettype none

module conditional_pixel_histogram_unit
    import cph_pkg::*;
#(
    parameter int NUM_BINS   = DEF_NUM_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // apb configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // pixel, mask_pixel, bin_select
    input  wire logic [FUNC_W-1:0]     s_tuser,   // func
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata    // bin_index, bin_count
);

    localparam int ADDR_W = $clog2(NUM_BINS);

    cfg_t                  cfg;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [COUNT_BITS-1:0] ram_rd_data;
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data;

    // configuration registers
    cph_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // bin memory
    cph_bin_ram #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    // read-modify-write pipeline
    cph_pipe #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

endmodule

`default_nettype wire

// ----- sv/cph_cfg_regs.sv -----
// apb configuration registers for compare mode and compare value
`default_nettype none

module cph_cfg_regs
    import cph_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [MODE_W-1:0] mode_reg;
    logic [PIX_W-1:0]  value_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes, word aligned decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            value_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_COMPARE_MODE:  mode_reg  <= pwdata[MODE_W-1:0];
                REG_COMPARE_VALUE: value_reg <= pwdata[PIX_W-1:0];
                default:           mode_reg  <= mode_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[2])
            REG_COMPARE_MODE:  prdata = APB_DATA_W'(mode_reg);
            REG_COMPARE_VALUE: prdata = APB_DATA_W'(value_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.mode  = mode_reg;
    assign cfg.value = value_reg;

endmodule

`default_nettype wire

// ----- sv/cph_bin_ram.sv -----
// bin count memory with registered read and per-entry valid bits
`default_nettype none

module cph_bin_ram
    import cph_pkg::*;
#(
    parameter int NUM_BINS   = DEF_NUM_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(NUM_BINS)-1:0]       rd_addr,
    output logic      [COUNT_BITS-1:0]             rd_data,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(NUM_BINS)-1:0]       wr_addr,
    input  wire logic [COUNT_BITS-1:0]             wr_data
);

    logic [COUNT_BITS-1:0] bin_mem_reg [NUM_BINS];
    logic [NUM_BINS-1:0]   valid_reg;
    logic [COUNT_BITS-1:0] rd_raw_reg;
    logic                  rd_valid_reg;

    // storage array, read before write on the same entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= bin_mem_reg[rd_addr];
        end
    end

    // valid bits, an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

// ----- sv/cph_pipe.sv -----
// read-modify-write pipeline with forwarding and output register
`default_nettype none

module cph_pipe
    import cph_pkg::*;
#(
    parameter int NUM_BINS   = DEF_NUM_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cfg_t                         cfg,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [S_DATA_W-1:0]          s_tdata,
    input  wire logic [FUNC_W-1:0]            s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [M_DATA_W-1:0]          m_tdata,
    output logic                              ram_rd_en,
    output logic      [$clog2(NUM_BINS)-1:0]  ram_rd_addr,
    input  wire logic [COUNT_BITS-1:0]        ram_rd_data,
    output logic                              ram_wr_en,
    output logic      [$clog2(NUM_BINS)-1:0]  ram_wr_addr,
    output logic      [COUNT_BITS-1:0]        ram_wr_data
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // input word fields
    logic [FUNC_W-1:0] in_func;
    logic [PIX_W-1:0]  in_pixel;
    logic [PIX_W-1:0]  in_mask;
    logic [PIX_W-1:0]  in_sel;
    logic [PIX_W-1:0]  in_idx;
    logic              in_accum;
    logic              in_read;
    logic              in_range;
    logic              accept;
    logic              advance;

    // stage one
    logic              s1_valid_reg;
    logic              s1_inc_reg;
    logic              s1_read_reg;
    logic              s1_clear_reg;
    logic              s1_range_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0]  s1_index_reg;

    // last write, for the entry read at the same edge
    logic                  fwd_valid_reg;
    logic [ADDR_W-1:0]     fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    // output register
    logic                  out_valid_reg;
    logic [PIX_W-1:0]      out_index_reg;
    logic [FIELD_W-1:0]    out_count_reg;

    logic [COUNT_BITS-1:0] old_count;
    logic [COUNT_BITS-1:0] new_count;
    logic [FIELD_W-1:0]    field_count;
    logic                  out_load;

    // decode the incoming word
    assign in_func  = s_tuser;
    assign in_pixel = s_tdata[PIX_W-1:0];
    assign in_mask  = s_tdata[2*PIX_W-1:PIX_W];
    assign in_sel   = s_tdata[3*PIX_W-1:2*PIX_W];
    assign in_accum = (in_func == FUNC_ACCUM);
    assign in_read  = (in_func == FUNC_READ) || (in_func == FUNC_READ_CLEAR);
    assign in_idx   = in_accum ? in_pixel : in_sel;
    assign in_range = ({1'b0, in_idx} < (PIX_W+1)'(NUM_BINS));

    // only a read waiting on a full output slot holds the pipe
    assign advance  = !(s1_valid_reg && s1_read_reg && out_valid_reg && !m_tready);
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    assign ram_rd_en   = advance;
    assign ram_rd_addr = in_idx[ADDR_W-1:0];

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_inc_reg   <= 1'b0;
            s1_read_reg  <= 1'b0;
            s1_clear_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s1_inc_reg   <= in_accum && in_range && cond_holds(cfg, in_mask);
            s1_read_reg  <= in_read;
            s1_clear_reg <= (in_func == FUNC_READ_CLEAR) && in_range;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_range_reg <= in_range;
            s1_addr_reg  <= in_idx[ADDR_W-1:0];
            s1_index_reg <= in_sel;
        end
    end

    // modify: forward the previous write, saturate or clear
    assign old_count = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
                       ? fwd_data_reg : ram_rd_data;
    assign new_count = s1_clear_reg ? '0 :
                       ((old_count == COUNT_MAX) ? old_count
                                                 : old_count + COUNT_BITS'(1));

    assign ram_wr_en   = s1_valid_reg && advance && (s1_inc_reg || s1_clear_reg);
    assign ram_wr_addr = s1_addr_reg;
    assign ram_wr_data = new_count;

    // forwarding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            fwd_valid_reg <= ram_wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_count;
        end
    end

    // count saturated or zero-extended to the result field
    generate
        if (COUNT_BITS > FIELD_W)
        begin : g_sat
            assign field_count = (|old_count[COUNT_BITS-1:FIELD_W]) ? '1
                                 : old_count[FIELD_W-1:0];
        end
        else
        begin : g_ext
            assign field_count = FIELD_W'(old_count);
        end
    endgenerate

    assign out_load = s1_valid_reg && s1_read_reg && advance;

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= s1_index_reg;
            out_count_reg <= s1_range_reg ? field_count : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_index_reg};

    // input stalls only behind a waiting read result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s1_read_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked read");

    // a clear always writes zero
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && s1_clear_reg) |-> (ram_wr_data == '0))
        else $error("clear wrote a nonzero count");

    // an increment never lowers a count
    a_inc_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && !s1_clear_reg) |-> (ram_wr_data >= old_count))
        else $error("increment lowered a count");

    // a stalled read leaves the bin untouched
    a_stall_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> !ram_wr_en)
        else $error("write during stall");

endmodule

`default_nettype wire
